@@ rtl/mcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh chunk stream parser package
// Chunk identifiers, result kinds and the parser phase type.
// ----------------------------------------------------------------------------
package mcsp_pkg;

  localparam int NAME_LIMIT = 20;

  localparam logic [15:0] ID_MAIN     = 16'h4D4D;
  localparam logic [15:0] ID_EDITOR   = 16'h3D3D;
  localparam logic [15:0] ID_OBJECT   = 16'h4000;
  localparam logic [15:0] ID_MESH     = 16'h4100;
  localparam logic [15:0] ID_VERTICES = 16'h4110;

  localparam logic [31:0] HEADER_BYTES = 32'd6;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_NAME      = 3'd1,
    KIND_COUNT     = 3'd2,
    KIND_COORD     = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_t;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_NAME   = 6'b000010,
    PH_COUNT  = 6'b000100,
    PH_VERTEX = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

endpackage

@@ rtl/mesh_chunk_stream_parser.sv @@
// ----------------------------------------------------------------------------
// Results are registered: the output register is loaded as the byte is accepted.
// Throughput: one byte per cycle; input stalls only while a held result is
// stalled by the result channel.
// The state update and result selection sit between the state registers and
// the result register.
// Reset returns the parser to header parsing and clears the output valid.
// ----------------------------------------------------------------------------
// Mesh chunk stream parser
// Parses a byte stream of little-endian chunks and reports headers, object
// names, vertex counts, coordinate words and malformed chunk headers.
// ----------------------------------------------------------------------------
module mesh_chunk_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_chunk_id,
  output logic [31:0] out_chunk_length,
  output logic [31:0] out_value,
  output logic [15:0] out_vertex_number,
  output logic [1:0]  out_axis,
  output logic        out_last
);

  mcsp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  byte_position_r, byte_position_nxt;
  logic [15:0] current_id_r, current_id_nxt;
  logic [31:0] current_length_r, current_length_nxt;
  logic [31:0] skip_remaining_r, skip_remaining_nxt;
  logic [15:0] vertex_total_r, vertex_total_nxt;
  logic [15:0] vertex_counter_r, vertex_counter_nxt;
  logic [1:0]  axis_counter_r, axis_counter_nxt;
  logic [31:0] word_assembly_r, word_assembly_nxt;

  logic        out_valid_r;
  logic [2:0]  kind_r, kind_nxt;
  logic [15:0] chunk_id_r;
  logic [31:0] chunk_length_r;
  logic [31:0] value_r, value_nxt;
  logic [15:0] vnum_r, vnum_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        last_r, last_nxt;
  logic        emit;

  logic        in_accept;
  logic        out_accept;
  logic [31:0] byte_ext;
  logic [31:0] len_part;
  logic [31:0] word_part;
  logic [16:0] vn_plus_one;

  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  assign byte_ext    = {24'd0, in_data_byte};
  assign len_part    = byte_ext << {byte_position_r[1:0] + 2'd2, 3'b000};
  assign word_part   = byte_ext << {byte_position_r[1:0], 3'b000};
  assign vn_plus_one = {1'b0, vertex_counter_r} + 17'd1;

  always_comb begin
    phase_nxt          = phase_r;
    byte_position_nxt  = byte_position_r;
    current_id_nxt     = current_id_r;
    current_length_nxt = current_length_r;
    skip_remaining_nxt = skip_remaining_r;
    vertex_total_nxt   = vertex_total_r;
    vertex_counter_nxt = vertex_counter_r;
    axis_counter_nxt   = axis_counter_r;
    word_assembly_nxt  = word_assembly_r;
    emit     = 1'b0;
    kind_nxt = mcsp_pkg::KIND_HEADER;
    value_nxt = 32'd0;
    vnum_nxt  = 16'd0;
    axis_nxt  = 2'd0;
    last_nxt  = 1'b0;
    unique case (phase_r)
      mcsp_pkg::PH_HEADER: begin
        if (byte_position_r == 5'd0) begin
          current_id_nxt = {8'd0, in_data_byte};
        end else if (byte_position_r == 5'd1) begin
          current_id_nxt = current_id_r | {in_data_byte, 8'd0};
        end else if (byte_position_r == 5'd2) begin
          current_length_nxt = byte_ext;
        end else begin
          current_length_nxt = current_length_r | len_part;
        end
        if (byte_position_r < 5'd5) begin
          byte_position_nxt = byte_position_r + 5'd1;
        end else begin
          byte_position_nxt = 5'd0;
          emit = 1'b1;
          if (current_length_nxt < mcsp_pkg::HEADER_BYTES) begin
            phase_nxt = mcsp_pkg::PH_HALT;
            kind_nxt  = mcsp_pkg::KIND_MALFORMED;
          end else if (current_id_nxt == mcsp_pkg::ID_MAIN ||
                       current_id_nxt == mcsp_pkg::ID_EDITOR ||
                       current_id_nxt == mcsp_pkg::ID_MESH) begin
            phase_nxt = mcsp_pkg::PH_HEADER;
          end else if (current_id_nxt == mcsp_pkg::ID_OBJECT) begin
            phase_nxt = mcsp_pkg::PH_NAME;
          end else if (current_id_nxt == mcsp_pkg::ID_VERTICES) begin
            phase_nxt = mcsp_pkg::PH_COUNT;
          end else begin
            skip_remaining_nxt = current_length_nxt - mcsp_pkg::HEADER_BYTES;
            phase_nxt = (skip_remaining_nxt == 32'd0) ? mcsp_pkg::PH_HEADER
                                                      : mcsp_pkg::PH_SKIP;
          end
        end
      end
      mcsp_pkg::PH_NAME: begin
        byte_position_nxt = byte_position_r + 5'd1;
        emit      = 1'b1;
        kind_nxt  = mcsp_pkg::KIND_NAME;
        value_nxt = byte_ext;
        last_nxt  = (in_data_byte == 8'd0) ||
                    (byte_position_nxt >= 5'(mcsp_pkg::NAME_LIMIT));
        if (last_nxt) begin
          byte_position_nxt = 5'd0;
          phase_nxt = mcsp_pkg::PH_HEADER;
        end
      end
      mcsp_pkg::PH_COUNT: begin
        if (byte_position_r == 5'd0) begin
          vertex_total_nxt  = {8'd0, in_data_byte};
          byte_position_nxt = 5'd1;
        end else begin
          vertex_total_nxt   = vertex_total_r | {in_data_byte, 8'd0};
          byte_position_nxt  = 5'd0;
          vertex_counter_nxt = 16'd0;
          axis_counter_nxt   = 2'd0;
          phase_nxt = (vertex_total_nxt == 16'd0) ? mcsp_pkg::PH_HEADER
                                                  : mcsp_pkg::PH_VERTEX;
          emit      = 1'b1;
          kind_nxt  = mcsp_pkg::KIND_COUNT;
          value_nxt = {16'd0, vertex_total_nxt};
        end
      end
      mcsp_pkg::PH_VERTEX: begin
        if (byte_position_r == 5'd0) begin
          word_assembly_nxt = byte_ext;
        end else begin
          word_assembly_nxt = word_assembly_r | word_part;
        end
        if (byte_position_r < 5'd3) begin
          byte_position_nxt = byte_position_r + 5'd1;
        end else begin
          byte_position_nxt = 5'd0;
          emit      = 1'b1;
          kind_nxt  = mcsp_pkg::KIND_COORD;
          value_nxt = word_assembly_nxt;
          vnum_nxt  = vertex_counter_r;
          axis_nxt  = axis_counter_r;
          last_nxt  = (axis_counter_r == 2'd2) &&
                      (vn_plus_one == {1'b0, vertex_total_r});
          if (axis_counter_r >= 2'd2) begin
            axis_counter_nxt   = 2'd0;
            vertex_counter_nxt = vn_plus_one[15:0];
            if (last_nxt) begin
              phase_nxt = mcsp_pkg::PH_HEADER;
            end
          end else begin
            axis_counter_nxt = axis_counter_r + 2'd1;
          end
        end
      end
      mcsp_pkg::PH_SKIP: begin
        if (skip_remaining_r != 32'd0) begin
          skip_remaining_nxt = skip_remaining_r - 32'd1;
        end
        if (skip_remaining_nxt == 32'd0) begin
          phase_nxt = mcsp_pkg::PH_HEADER;
          byte_position_nxt = 5'd0;
        end
      end
      mcsp_pkg::PH_HALT: begin
        phase_nxt = mcsp_pkg::PH_HALT;
      end
      default: begin
        phase_nxt = mcsp_pkg::PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= mcsp_pkg::PH_HEADER;
      byte_position_r  <= 5'd0;
      current_id_r     <= 16'd0;
      current_length_r <= 32'd0;
      skip_remaining_r <= 32'd0;
      vertex_total_r   <= 16'd0;
      vertex_counter_r <= 16'd0;
      axis_counter_r   <= 2'd0;
      word_assembly_r  <= 32'd0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r          <= phase_nxt;
        byte_position_r  <= byte_position_nxt;
        current_id_r     <= current_id_nxt;
        current_length_r <= current_length_nxt;
        skip_remaining_r <= skip_remaining_nxt;
        vertex_total_r   <= vertex_total_nxt;
        vertex_counter_r <= vertex_counter_nxt;
        axis_counter_r   <= axis_counter_nxt;
        word_assembly_r  <= word_assembly_nxt;
      end
      if (in_accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      kind_r         <= kind_nxt;
      chunk_id_r     <= current_id_nxt;
      chunk_length_r <= current_length_nxt;
      value_r        <= value_nxt;
      vnum_r         <= vnum_nxt;
      axis_r         <= axis_nxt;
      last_r         <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_chunk_id      = chunk_id_r;
  assign out_chunk_length  = chunk_length_r;
  assign out_value         = value_r;
  assign out_vertex_number = vnum_r;
  assign out_axis          = axis_r;
  assign out_last          = last_r;

endmodule
